// ===== design/gtp_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, codes, types and the arctangent table of the go-to-point controller
package gtp_pkg;

  localparam int POS_W   = 32;
  localparam int HEAD_W  = 19;
  localparam int VEL_W   = 19;
  localparam int DIST_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int TOL_W   = 16;
  localparam int LIM_W   = 18;
  localparam int DIFF_W  = 33;
  localparam int XY_W    = 37;
  localparam int ANG_W   = 35;
  localparam int GAIN_SH = 8;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 152;
  localparam int OUT_DW  = 72;

  localparam logic signed [ANG_W-1:0] PI_Q30     = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] NEG_PI_Q30 = -35'sd3373259426;
  localparam logic [15:0]             INV_GAIN_Q16 = 16'd39797;
  localparam int                      INV_GAIN_SH  = 16;

  localparam logic [TOL_W-1:0]  RST_DIST_TOL   = 16'd3277;
  localparam logic [TOL_W-1:0]  RST_HEAD_TOL   = 16'd4575;
  localparam logic [GAIN_W-1:0] RST_TURN_GAIN  = 16'd3840;
  localparam logic [GAIN_W-1:0] RST_DRIVE_GAIN = 16'd2560;
  localparam logic [LIM_W-1:0]  RST_TURN_LIM   = 18'd42598;
  localparam logic [LIM_W-1:0]  RST_DRIVE_LIM  = 18'd55706;

  typedef enum logic [1:0] {
    MODE_TURN    = 2'd0,
    MODE_DRIVE   = 2'd1,
    MODE_REACHED = 2'd2,
    MODE_CANCEL  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_DIST_TOL   = 3'd0,
    REG_HEAD_TOL   = 3'd1,
    REG_TURN_GAIN  = 3'd2,
    REG_DRIVE_GAIN = 3'd3,
    REG_TURN_LIM   = 3'd4,
    REG_DRIVE_LIM  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic                     cancel;
  } side_t;

  typedef struct packed {
    logic [TOL_W-1:0]  dist_tol;
    logic [TOL_W-1:0]  head_tol;
    logic [GAIN_W-1:0] turn_gain;
    logic [GAIN_W-1:0] drive_gain;
    logic [LIM_W-1:0]  turn_lim;
    logic [LIM_W-1:0]  drive_lim;
  } cfg_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] lin;
    logic signed [VEL_W-1:0] ang;
    mode_t                   mode;
    logic [DIST_W-1:0]       dist_err;
  } res_t;

  // atan(2^-i) in Q30, exact powers of two once the small angle form holds
  function automatic logic [ANG_W-1:0] atan_q30(input int unsigned idx);
    logic [ANG_W-1:0] val;
    case (idx)
      0:       val = 35'd843314857;
      1:       val = 35'd497837829;
      2:       val = 35'd263043837;
      3:       val = 35'd133525159;
      4:       val = 35'd67021687;
      5:       val = 35'd33543516;
      6:       val = 35'd16775851;
      7:       val = 35'd8388437;
      8:       val = 35'd4194283;
      9:       val = 35'd2097149;
      default: val = ANG_W'(64'd1 << (30 - idx));
    endcase
    return val;
  endfunction

endpackage

// ===== design/gtp_prep.sv =====
`timescale 1ns / 1ps
// input stage: goal offset and half-plane pre-rotation ahead of the cordic row
module gtp_prep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [gtp_pkg::POS_W-1:0]  robot_x,
  input  logic signed [gtp_pkg::POS_W-1:0]  robot_y,
  input  logic signed [gtp_pkg::HEAD_W-1:0] heading,
  input  logic signed [gtp_pkg::POS_W-1:0]  goal_x,
  input  logic signed [gtp_pkg::POS_W-1:0]  goal_y,
  input  logic                              cancel,
  output logic                              out_valid,
  output gtp_pkg::vec_t                     out_vec,
  output gtp_pkg::side_t                    out_side
);

  localparam int DW = gtp_pkg::DIFF_W;
  localparam int XW = gtp_pkg::XY_W;

  logic signed [DW-1:0] dx, dy, ndx, ndy;
  logic                 vld_r;
  gtp_pkg::vec_t        vec_r, vec_nxt;
  gtp_pkg::side_t       side_r;

  // both directions in parallel, the sign of dx picks one
  assign dx  = DW'(goal_x) - DW'(robot_x);
  assign dy  = DW'(goal_y) - DW'(robot_y);
  assign ndx = DW'(robot_x) - DW'(goal_x);
  assign ndy = DW'(robot_y) - DW'(goal_y);

  always_comb begin
    if (dx[DW-1]) begin
      vec_nxt.x = XW'(ndx);
      vec_nxt.y = XW'(ndy);
      vec_nxt.z = dy[DW-1] ? gtp_pkg::NEG_PI_Q30 : gtp_pkg::PI_Q30;
    end else begin
      vec_nxt.x = XW'(dx);
      vec_nxt.y = XW'(dy);
      vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r          <= vec_nxt;
      side_r.heading <= heading;
      side_r.cancel  <= cancel;
    end
  end

  assign out_valid = vld_r;
  assign out_vec   = vec_r;
  assign out_side  = side_r;

endmodule

// ===== design/gtp_cordic_cell.sv =====
`timescale 1ns / 1ps
// one vectoring micro-rotation of the cordic row
module gtp_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  gtp_pkg::vec_t  in_vec,
  input  gtp_pkg::side_t in_side,
  output logic           out_valid,
  output gtp_pkg::vec_t  out_vec,
  output gtp_pkg::side_t out_side
);

  localparam int XW = gtp_pkg::XY_W;
  localparam logic signed [gtp_pkg::ANG_W-1:0] STEP = gtp_pkg::atan_q30(SHIFT);

  logic signed [XW-1:0] xs, ys;
  gtp_pkg::vec_t        vec_r, vec_nxt;
  gtp_pkg::side_t       side_r;
  logic                 vld_r;

  // arithmetic shift gives the floor
  assign xs = in_vec.x >>> SHIFT;
  assign ys = in_vec.y >>> SHIFT;

  always_comb begin
    if (!in_vec.y[XW-1]) begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + STEP;
    end else begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r  <= vec_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = vld_r;
  assign out_vec   = vec_r;
  assign out_side  = side_r;

endmodule

// ===== design/gtp_post.sv =====
`timescale 1ns / 1ps
// back end: bearing and distance scaling, heading wrap, mode pick, gains and clamps
module gtp_post #(
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  gtp_pkg::vec_t  in_vec,
  input  gtp_pkg::side_t in_side,
  input  gtp_pkg::cfg_t  cfg,
  output logic           out_valid,
  output gtp_pkg::res_t  out_res
);

  localparam int AW   = gtp_pkg::ANG_W;
  localparam int HW   = gtp_pkg::HEAD_W;
  localparam int GW   = gtp_pkg::GAIN_W;
  localparam int LW   = gtp_pkg::LIM_W;
  localparam int VLW  = gtp_pkg::VEL_W;
  localparam int OW   = gtp_pkg::DIST_W;
  localparam int GSH  = gtp_pkg::GAIN_SH;
  localparam int DW   = gtp_pkg::XY_W - 1;
  localparam int ISH  = gtp_pkg::INV_GAIN_SH;
  localparam int DPW  = DW + ISH;
  localparam int SH   = 30 - FRACTION_BITS;
  localparam longint PI_Q   = (longint'(gtp_pkg::PI_Q30) + (longint'(1) << (SH - 1))) >>> SH;
  localparam longint TWO_PI = 2 * PI_Q;
  // bearing stays below 2^(FRACTION_BITS+3), the heading field adds its own range
  localparam int VW   = ((FRACTION_BITS + 5 > HW) ? FRACTION_BITS + 5 : HW) + 2;
  localparam longint RECIP = (longint'(1) << VW) / TWO_PI;
  localparam int RW   = $clog2(RECIP + 1) + 1;
  localparam int QW   = RW + 1;
  localparam int TW   = $clog2(TWO_PI + 1) + 1;
  localparam int EW   = TW - 1;
  localparam int RW2  = VW + 2;
  localparam int APW  = GW + EW;
  localparam int LPW  = GW + DW;
  localparam int AMW  = APW - GSH;
  localparam int LMW  = LPW - GSH;
  localparam int NST  = 9;

  localparam logic signed [AW-1:0]  RND_HALF   = AW'(longint'(1) << (SH - 1));
  localparam logic signed [VW-1:0]  PI_V       = VW'(PI_Q);
  localparam logic signed [RW-1:0]  RECIP_S    = RW'(RECIP);
  localparam logic signed [TW-1:0]  TWO_PI_S   = TW'(TWO_PI);
  localparam logic signed [RW2-1:0] PI_R       = RW2'(PI_Q);
  localparam logic signed [RW2-1:0] THREE_PI_R = RW2'(3 * PI_Q);
  localparam logic signed [RW2-1:0] TWO_PI_R   = RW2'(TWO_PI);
  localparam logic [DPW-1:0]        DIST_RND   = DPW'(longint'(1) << (ISH - 1));

  logic [NST-1:0] vld_r;

  // stage 1
  logic signed [AW-1:0]  bear_full;
  logic signed [VW-1:0]  bear1_r, bear1_nxt;
  logic [DPW-1:0]        dprod1_r, dprod1_nxt;
  logic signed [HW-1:0]  hd1_r;
  // stage 2
  logic signed [VW-1:0]  v2_r, v2_nxt;
  logic [DPW-1:0]        dsum;
  logic [DW-1:0]         dist2_r, dist2_nxt;
  // stage 3
  logic signed [VW+RW-1:0] qprod3_r, qprod3_nxt;
  logic signed [VW-1:0]    v3_r;
  logic [DW-1:0]           dist3_r;
  // stage 4
  logic signed [QW-1:0]    q_est;
  logic signed [QW+TW-1:0] qt4_r, qt4_nxt;
  logic signed [VW-1:0]    v4_r;
  logic [DW-1:0]           dist4_r;
  // stage 5
  logic signed [RW2-1:0] r05_r, r05_nxt;
  logic [DW-1:0]         dist5_r;
  // stage 6
  logic signed [RW2-1:0] err_sel;
  logic signed [TW-1:0]  err6_r, err6_nxt;
  logic [DW-1:0]         dist6_r;
  // stage 7
  logic [EW-1:0]         aerr7_r, aerr7_nxt;
  logic                  neg7_r;
  logic [DW-1:0]         dist7_r;
  // stage 8
  gtp_pkg::mode_t        mode8_r, mode8_nxt;
  logic [APW-1:0]        aprod8_r, aprod8_nxt;
  logic [LPW-1:0]        lprod8_r, lprod8_nxt;
  logic                  neg8_r;
  logic [DW-1:0]         dist8_r;
  // stage 9
  logic [AMW-1:0]        amag;
  logic [LMW-1:0]        lmag;
  logic [LW-1:0]         aclip, lclip;
  gtp_pkg::res_t         res9_r, res9_nxt;

  logic c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r;

  always_comb begin
    bear_full  = (in_vec.z + RND_HALF) >>> SH;
    bear1_nxt  = VW'(bear_full);
    dprod1_nxt = in_vec.x[DW-1:0] * gtp_pkg::INV_GAIN_Q16;

    v2_nxt    = bear1_r - VW'(hd1_r) + PI_V;
    dsum      = dprod1_r + DIST_RND;
    dist2_nxt = dsum[DPW-1:ISH];

    // quotient estimate by reciprocal, off by at most one either way
    qprod3_nxt = v2_r * RECIP_S;

    q_est   = QW'(qprod3_r >>> VW);
    qt4_nxt = q_est * TWO_PI_S;

    r05_nxt = RW2'(v4_r) - RW2'(qt4_r);

    // fold the remainder into one period and center it on zero
    if (r05_r[RW2-1]) begin
      err_sel = r05_r + PI_R;
    end else if (r05_r >= TWO_PI_R) begin
      err_sel = r05_r - THREE_PI_R;
    end else begin
      err_sel = r05_r - PI_R;
    end
    err6_nxt = TW'(err_sel);

    aerr7_nxt = err6_r[TW-1] ? EW'(-err6_r) : EW'(err6_r);

    if (c7_r) begin
      mode8_nxt = gtp_pkg::MODE_CANCEL;
    end else if (dist7_r <= DW'(cfg.dist_tol)) begin
      mode8_nxt = gtp_pkg::MODE_REACHED;
    end else if (32'(aerr7_r) > 32'(cfg.head_tol)) begin
      mode8_nxt = gtp_pkg::MODE_TURN;
    end else begin
      mode8_nxt = gtp_pkg::MODE_DRIVE;
    end
    aprod8_nxt = cfg.turn_gain * aerr7_r;
    lprod8_nxt = cfg.drive_gain * dist7_r;

    amag  = aprod8_r[APW-1:GSH];
    lmag  = lprod8_r[LPW-1:GSH];
    aclip = (amag > AMW'(cfg.turn_lim)) ? cfg.turn_lim : amag[LW-1:0];
    lclip = (lmag > LMW'(cfg.drive_lim)) ? cfg.drive_lim : lmag[LW-1:0];

    res9_nxt.mode = mode8_r;
    res9_nxt.lin  = '0;
    res9_nxt.ang  = '0;
    if (mode8_r == gtp_pkg::MODE_TURN) begin
      res9_nxt.ang = neg8_r ? VLW'(0) - VLW'(aclip) : VLW'(aclip);
    end
    if (mode8_r == gtp_pkg::MODE_DRIVE) begin
      res9_nxt.lin = VLW'(lclip);
    end
    res9_nxt.dist_err = (dist8_r[DW-1:OW] != '0) ? '1 : dist8_r[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bear1_r  <= bear1_nxt;
      dprod1_r <= dprod1_nxt;
      hd1_r    <= in_side.heading;
      c1_r     <= in_side.cancel;

      v2_r    <= v2_nxt;
      dist2_r <= dist2_nxt;
      c2_r    <= c1_r;

      qprod3_r <= qprod3_nxt;
      v3_r     <= v2_r;
      dist3_r  <= dist2_r;
      c3_r     <= c2_r;

      qt4_r   <= qt4_nxt;
      v4_r    <= v3_r;
      dist4_r <= dist3_r;
      c4_r    <= c3_r;

      r05_r   <= r05_nxt;
      dist5_r <= dist4_r;
      c5_r    <= c4_r;

      err6_r  <= err6_nxt;
      dist6_r <= dist5_r;
      c6_r    <= c5_r;

      aerr7_r <= aerr7_nxt;
      neg7_r  <= err6_r[TW-1];
      dist7_r <= dist6_r;
      c7_r    <= c6_r;

      mode8_r  <= mode8_nxt;
      aprod8_r <= aprod8_nxt;
      lprod8_r <= lprod8_nxt;
      neg8_r   <= neg7_r;
      dist8_r  <= dist7_r;

      res9_r <= res9_nxt;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_res   = res9_r;

endmodule

// ===== design/go_to_point_controller.sv =====
`timescale 1ns / 1ps
// go-to-point controller: one pose beat in, one command beat out per clock unless stalled
// from acceptance to out_tvalid: prep register, cordic cells, nine post stages, output register
// throughput: one beat per cycle unless stalled, set by the cordic cells and nine post stages
// a two-entry output buffer decouples out_tready from in_tready; a stall freezes the pipe
// reset (rst_n low at a clock edge) empties the pipe and loads the default tolerances and gains
module go_to_point_controller #(
  parameter int CORDIC_STAGES = 18,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // robot_x, robot_y, robot_heading, goal_x, goal_y from bit 0 up, zero padded
  input  logic [gtp_pkg::IN_DW-1:0]     in_tdata,
  // cancel_request
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // linear_velocity, angular_velocity, distance_error from bit 0 up, zero padded
  output logic [gtp_pkg::OUT_DW-1:0]    out_tdata,
  // mode
  output logic [1:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gtp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [gtp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [gtp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  localparam int PW = gtp_pkg::POS_W;
  localparam int HW = gtp_pkg::HEAD_W;
  localparam int DW = gtp_pkg::CFG_DW;

  gtp_pkg::cfg_t     cfg_r, cfg_nxt;
  gtp_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  logic              en;
  logic              cell_vld  [0:CORDIC_STAGES];
  gtp_pkg::vec_t     cell_vec  [0:CORDIC_STAGES];
  gtp_pkg::side_t    cell_side [0:CORDIC_STAGES];
  logic              post_vld;
  gtp_pkg::res_t     post_res;

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  gtp_pkg::res_t     out_res_r, out_res_nxt;
  gtp_pkg::res_t     skid_res_r, skid_res_nxt;
  logic              push;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = gtp_pkg::reg_idx_t'(cfg_paddr[gtp_pkg::CFG_AW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        gtp_pkg::REG_DIST_TOL:   cfg_nxt.dist_tol   = cfg_pwdata[gtp_pkg::TOL_W-1:0];
        gtp_pkg::REG_HEAD_TOL:   cfg_nxt.head_tol   = cfg_pwdata[gtp_pkg::TOL_W-1:0];
        gtp_pkg::REG_TURN_GAIN:  cfg_nxt.turn_gain  = cfg_pwdata[gtp_pkg::GAIN_W-1:0];
        gtp_pkg::REG_DRIVE_GAIN: cfg_nxt.drive_gain = cfg_pwdata[gtp_pkg::GAIN_W-1:0];
        gtp_pkg::REG_TURN_LIM:   cfg_nxt.turn_lim   = cfg_pwdata[gtp_pkg::LIM_W-1:0];
        gtp_pkg::REG_DRIVE_LIM:  cfg_nxt.drive_lim  = cfg_pwdata[gtp_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gtp_pkg::REG_DIST_TOL:   cfg_prdata = DW'(cfg_r.dist_tol);
      gtp_pkg::REG_HEAD_TOL:   cfg_prdata = DW'(cfg_r.head_tol);
      gtp_pkg::REG_TURN_GAIN:  cfg_prdata = DW'(cfg_r.turn_gain);
      gtp_pkg::REG_DRIVE_GAIN: cfg_prdata = DW'(cfg_r.drive_gain);
      gtp_pkg::REG_TURN_LIM:   cfg_prdata = DW'(cfg_r.turn_lim);
      gtp_pkg::REG_DRIVE_LIM:  cfg_prdata = DW'(cfg_r.drive_lim);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_tol   <= gtp_pkg::RST_DIST_TOL;
      cfg_r.head_tol   <= gtp_pkg::RST_HEAD_TOL;
      cfg_r.turn_gain  <= gtp_pkg::RST_TURN_GAIN;
      cfg_r.drive_gain <= gtp_pkg::RST_DRIVE_GAIN;
      cfg_r.turn_lim   <= gtp_pkg::RST_TURN_LIM;
      cfg_r.drive_lim  <= gtp_pkg::RST_DRIVE_LIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // the pipe moves whenever the skid entry is free
  assign en        = ~skid_vld_r;
  assign in_tready = en;

  gtp_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .robot_x   (in_tdata[PW-1:0]),
    .robot_y   (in_tdata[2*PW-1:PW]),
    .heading   (in_tdata[2*PW+HW-1:2*PW]),
    .goal_x    (in_tdata[3*PW+HW-1:2*PW+HW]),
    .goal_y    (in_tdata[4*PW+HW-1:3*PW+HW]),
    .cancel    (in_tuser),
    .out_valid (cell_vld[0]),
    .out_vec   (cell_vec[0]),
    .out_side  (cell_side[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    gtp_cordic_cell #(
      .SHIFT (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cell_vld[g]),
      .in_vec    (cell_vec[g]),
      .in_side   (cell_side[g]),
      .out_valid (cell_vld[g+1]),
      .out_vec   (cell_vec[g+1]),
      .out_side  (cell_side[g+1])
    );
  end

  gtp_post #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cell_vld[CORDIC_STAGES]),
    .in_vec    (cell_vec[CORDIC_STAGES]),
    .in_side   (cell_side[CORDIC_STAGES]),
    .cfg       (cfg_r),
    .out_valid (post_vld),
    .out_res   (post_res)
  );

  // output register plus skid entry
  assign push = en & post_vld;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_res_nxt  = skid_res_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_res_nxt = post_res;
        out_vld_nxt = push;
      end
    end else if (push) begin
      skid_res_nxt = post_res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.mode;
  assign out_tdata  = {2'b00, out_res_r.dist_err, out_res_r.ang, out_res_r.lin};

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry holds a beat while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid entry filled without a stalled output beat");

  a_cancel_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gtp_pkg::MODE_CANCEL) |->
      (out_res_r.lin == '0 && out_res_r.ang == '0))
    else $error("cancel beat carries a nonzero velocity");

  a_turn_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gtp_pkg::MODE_TURN) |-> out_res_r.lin == '0)
    else $error("turning beat carries a linear velocity");

  a_drive_straight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == gtp_pkg::MODE_DRIVE) |-> out_res_r.ang == '0)
    else $error("driving beat carries an angular velocity");
`endif

endmodule

// ===== sim/tb_go_to_point_controller.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the go-to-point controller: predicted commands vs. stream output
module tb_go_to_point_controller;

  localparam int     CORDIC_ROUNDS   = 18;
  localparam int     Q_BITS          = 16;
  localparam int     ANGLE_SH        = 30 - Q_BITS;
  localparam longint HALF_TURN_Q30   = 64'sd3373259426;
  localparam longint HALF_TURN_Q     = (HALF_TURN_Q30 + (64'sd1 <<< (ANGLE_SH - 1))) >>> ANGLE_SH;
  localparam longint FULL_TURN_Q     = 2 * HALF_TURN_Q;
  localparam longint CORDIC_INV_GAIN = 64'sd39797;
  localparam longint DIST_SAT        = 64'sd4294967295;
  localparam longint POS_MIN         = -64'sd2147483648;
  localparam longint POS_MAX         = 64'sd2147483647;
  localparam longint ONE_M           = 64'sd65536;
  localparam logic [2:0] SPARE_REG   = 3'd6;
  localparam int     LATENCY         = CORDIC_ROUNDS + 10;
  localparam int     CYCLE_LIMIT     = 200000;
  localparam int     MAX_PRINTS      = 40;

  typedef struct {
    logic signed [gtp_pkg::POS_W-1:0]  rx;
    logic signed [gtp_pkg::POS_W-1:0]  ry;
    logic signed [gtp_pkg::HEAD_W-1:0] hd;
    logic signed [gtp_pkg::POS_W-1:0]  gx;
    logic signed [gtp_pkg::POS_W-1:0]  gy;
    logic                              cancel;
  } pose_t;

  logic                       clk;
  logic                       rst_n;
  // robot_x, robot_y, robot_heading, goal_x, goal_y from bit 0 up, zero padded
  logic [gtp_pkg::IN_DW-1:0]  in_tdata;
  // cancel_request
  logic                       in_tuser;
  logic                       in_tvalid;
  logic                       in_tready;
  // linear_velocity, angular_velocity, distance_error from bit 0 up, zero padded
  logic [gtp_pkg::OUT_DW-1:0] out_tdata;
  // mode
  logic [1:0]                 out_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [gtp_pkg::CFG_AW-1:0] cfg_paddr;
  logic [gtp_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [gtp_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  gtp_pkg::cfg_t settings;
  gtp_pkg::res_t commands_due[$];
  int   errors;
  int   prints;
  int   poses_in;
  int   commands_out;
  int   cycles;
  int   settings_used;
  int   gap_pct;
  int   stall_pct;
  int   mode_seen[4];

  go_to_point_controller dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint arctan_q30(input int idx);
    case (idx)
      0:       return 64'sd843314857;
      1:       return 64'sd497837829;
      2:       return 64'sd263043837;
      3:       return 64'sd133525159;
      4:       return 64'sd67021687;
      5:       return 64'sd33543516;
      6:       return 64'sd16775851;
      7:       return 64'sd8388437;
      8:       return 64'sd4194283;
      9:       return 64'sd2097149;
      default: return 64'sd1 <<< (30 - idx);
    endcase
  endfunction

  // bearing in Q16 radians and unsaturated distance in Q16 meters
  function automatic void vector_to_goal(input pose_t p, output longint bearing,
                                         output longint range_q);
    longint x, y, z, xs, ys;
    int i;
    x = longint'(p.gx) - longint'(p.rx);
    y = longint'(p.gy) - longint'(p.ry);
    z = 0;
    // left half plane: mirror into the right half and start from +-pi
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
      x = -x;
      y = -y;
    end
    for (i = 0; i < CORDIC_ROUNDS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q30(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q30(i);
      end
    end
    bearing = (z + (64'sd1 <<< (ANGLE_SH - 1))) >>> ANGLE_SH;
    range_q = (x * CORDIC_INV_GAIN + 64'sd32768) >>> 16;
  endfunction

  function automatic longint proportional(input longint gain, input longint e,
                                          input longint limit);
    longint v;
    v = (gain * ((e < 0) ? -e : e)) >>> gtp_pkg::GAIN_SH;
    if (v > limit) v = limit;
    return (e < 0) ? -v : v;
  endfunction

  function automatic gtp_pkg::res_t predict_command(input pose_t p);
    gtp_pkg::res_t c;
    longint        bearing, range_q, err, lin, ang;
    vector_to_goal(p, bearing, range_q);
    err = (bearing - longint'(p.hd) + HALF_TURN_Q) % FULL_TURN_Q;
    if (err < 0) err = err + FULL_TURN_Q;
    err = err - HALF_TURN_Q;
    lin = 0;
    ang = 0;
    if (p.cancel) begin
      c.mode = gtp_pkg::MODE_CANCEL;
    end else if (range_q <= longint'(settings.dist_tol)) begin
      c.mode = gtp_pkg::MODE_REACHED;
    end else if (((err < 0) ? -err : err) > longint'(settings.head_tol)) begin
      c.mode = gtp_pkg::MODE_TURN;
      ang = proportional(settings.turn_gain, err, settings.turn_lim);
    end else begin
      c.mode = gtp_pkg::MODE_DRIVE;
      lin = proportional(settings.drive_gain, range_q, settings.drive_lim);
    end
    c.lin      = lin[gtp_pkg::VEL_W-1:0];
    c.ang      = ang[gtp_pkg::VEL_W-1:0];
    c.dist_err = (range_q > DIST_SAT) ? {gtp_pkg::DIST_W{1'b1}} :
                                        range_q[gtp_pkg::DIST_W-1:0];
    return c;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic pose_t pose_of(input longint rx, input longint ry, input longint hd,
                                    input longint gx, input longint gy, input bit cancel);
    pose_t p;
    p.rx     = rx[gtp_pkg::POS_W-1:0];
    p.ry     = ry[gtp_pkg::POS_W-1:0];
    p.hd     = hd[gtp_pkg::HEAD_W-1:0];
    p.gx     = gx[gtp_pkg::POS_W-1:0];
    p.gy     = gy[gtp_pkg::POS_W-1:0];
    p.cancel = cancel;
    return p;
  endfunction

  // uniform in [-2^bits, 2^bits - 1]
  function automatic longint spread(input int bits);
    return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (64'sd1 <<< bits);
  endfunction

  function automatic pose_t random_pose();
    pose_t  p;
    longint rx, ry, dx, dy, hd, bearing, range_q;
    int     kind;
    int     tol;
    kind = $urandom_range(0, 99);
    rx = longint'($signed($urandom));
    ry = longint'($signed($urandom));
    dx = spread($urandom_range(2, 24));
    dy = spread($urandom_range(2, 24));
    hd = longint'($urandom_range(0, FULL_TURN_Q)) - HALF_TURN_Q;
    if (kind < 8) begin
      return pose_of(rx, ry, spread(18), rx + dx, ry + dy, 1'b1);
    end
    if (kind < 20) begin
      // close to the goal, straddling the distance tolerance
      dx = spread($urandom_range(0, 13));
      dy = spread($urandom_range(0, 13));
    end else if (kind >= 85) begin
      dx = longint'($signed($urandom)) - rx;
      dy = longint'($signed($urandom)) - ry;
      hd = spread(18);
    end
    p = pose_of(rx, ry, hd, rx + dx, ry + dy, 1'b0);
    if (kind >= 20 && kind < 60) begin
      // roughly facing the goal, straddling the heading tolerance
      vector_to_goal(p, bearing, range_q);
      tol = settings.head_tol;
      hd = bearing + longint'($urandom_range(0, 2 * tol + 2)) - tol - 1;
      p.hd = hd[gtp_pkg::HEAD_W-1:0];
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (prints < MAX_PRINTS)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    prints++;
  endtask

  // ---------------------------------------------------------------- stream side

  task automatic send_pose(input pose_t p);
    logic [gtp_pkg::IN_DW-1:0] beat;
    beat = '0;
    beat[146:0] = {p.gy, p.gx, p.hd, p.ry, p.rx};
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tdata  <= beat;
    in_tuser  <= p.cancel;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (commands_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    gtp_pkg::res_t want;
    pose_t         seen;
    if (rst_n && out_tvalid && out_tready) begin
      commands_out++;
      if (commands_due.size() == 0) begin
        report_mismatch("command with no pose pending", out_tuser, -1);
      end else begin
        want = commands_due.pop_front();
        mode_seen[want.mode]++;
        if (out_tdata[gtp_pkg::VEL_W-1:0] !== want.lin)
          report_mismatch("linear_velocity", $signed(out_tdata[gtp_pkg::VEL_W-1:0]),
                          want.lin);
        if (out_tdata[2*gtp_pkg::VEL_W-1:gtp_pkg::VEL_W] !== want.ang)
          report_mismatch("angular_velocity",
                          $signed(out_tdata[2*gtp_pkg::VEL_W-1:gtp_pkg::VEL_W]), want.ang);
        if (out_tdata[2*gtp_pkg::VEL_W+gtp_pkg::DIST_W-1:2*gtp_pkg::VEL_W] !== want.dist_err)
          report_mismatch("distance_error",
                          out_tdata[2*gtp_pkg::VEL_W+gtp_pkg::DIST_W-1:2*gtp_pkg::VEL_W],
                          want.dist_err);
        if (out_tuser !== want.mode)
          report_mismatch("mode", out_tuser, want.mode);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      seen.rx     = in_tdata[31:0];
      seen.ry     = in_tdata[63:32];
      seen.hd     = in_tdata[82:64];
      seen.gx     = in_tdata[114:83];
      seen.gy     = in_tdata[146:115];
      seen.cancel = in_tuser;
      commands_due.push_back(predict_command(seen));
      poses_in++;
    end
  end

  // ---------------------------------------------------------------- register port

  task automatic write_register(input logic [2:0] idx,
                                input logic [gtp_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      gtp_pkg::REG_DIST_TOL:   settings.dist_tol   = value[gtp_pkg::TOL_W-1:0];
      gtp_pkg::REG_HEAD_TOL:   settings.head_tol   = value[gtp_pkg::TOL_W-1:0];
      gtp_pkg::REG_TURN_GAIN:  settings.turn_gain  = value[gtp_pkg::GAIN_W-1:0];
      gtp_pkg::REG_DRIVE_GAIN: settings.drive_gain = value[gtp_pkg::GAIN_W-1:0];
      gtp_pkg::REG_TURN_LIM:   settings.turn_lim   = value[gtp_pkg::LIM_W-1:0];
      gtp_pkg::REG_DRIVE_LIM:  settings.drive_lim  = value[gtp_pkg::LIM_W-1:0];
      default: ;
    endcase
    // bus idle between transfers
    @(posedge clk);
  endtask

  task automatic verify_registers();
    logic [2:0]                 idx;
    logic [gtp_pkg::CFG_DW-1:0] want;
    logic [gtp_pkg::CFG_DW-1:0] got;
    int                         i;
    for (i = 0; i < 6; i++) begin
      idx = i[2:0];
      case (idx)
        gtp_pkg::REG_DIST_TOL:   want = gtp_pkg::CFG_DW'(settings.dist_tol);
        gtp_pkg::REG_HEAD_TOL:   want = gtp_pkg::CFG_DW'(settings.head_tol);
        gtp_pkg::REG_TURN_GAIN:  want = gtp_pkg::CFG_DW'(settings.turn_gain);
        gtp_pkg::REG_DRIVE_GAIN: want = gtp_pkg::CFG_DW'(settings.drive_gain);
        gtp_pkg::REG_TURN_LIM:   want = gtp_pkg::CFG_DW'(settings.turn_lim);
        default:                 want = gtp_pkg::CFG_DW'(settings.drive_lim);
      endcase
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= {idx, 2'b00};
      @(posedge clk);
      cfg_penable <= 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      got = cfg_prdata;
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      @(posedge clk);
      if (got !== want) report_mismatch($sformatf("register %0d readback", i), got, want);
    end
  endtask

  task automatic apply_settings(input logic [gtp_pkg::CFG_DW-1:0] dist_tol, head_tol,
                                turn_gain,
                                input logic [gtp_pkg::CFG_DW-1:0] drive_gain, turn_lim,
                                drive_lim);
    write_register(gtp_pkg::REG_DIST_TOL, dist_tol);
    write_register(gtp_pkg::REG_HEAD_TOL, head_tol);
    write_register(gtp_pkg::REG_TURN_GAIN, turn_gain);
    write_register(gtp_pkg::REG_DRIVE_GAIN, drive_gain);
    write_register(gtp_pkg::REG_TURN_LIM, turn_lim);
    write_register(gtp_pkg::REG_DRIVE_LIM, drive_lim);
    verify_registers();
    settings_used++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    verify_registers();
    settings_used++;
  endtask

  task automatic test_directed_poses();
    send_pose(pose_of(0, 0, 0, 0, 0, 1'b0));                       // on the goal
    send_pose(pose_of(0, 0, 0, 0, 0, 1'b1));                       // cancel on the goal
    send_pose(pose_of(0, 0, 12345, 50 * ONE_M, -7 * ONE_M, 1'b1)); // cancel far away
    send_pose(pose_of(POS_MIN, POS_MIN, 0, POS_MAX, POS_MAX, 1'b0));
    send_pose(pose_of(POS_MAX, POS_MAX, 0, POS_MIN, POS_MIN, 1'b0));
    send_pose(pose_of(POS_MAX, POS_MIN, -HALF_TURN_Q, POS_MIN, POS_MAX, 1'b0));
    // goal straight behind along -x: bearing starts at +pi
    send_pose(pose_of(0, 0, HALF_TURN_Q, -5 * ONE_M, 0, 1'b0));
    send_pose(pose_of(0, 0, -HALF_TURN_Q, -5 * ONE_M, 0, 1'b0));
    // headings outside +-pi wrap
    send_pose(pose_of(0, 0, 262143, 3 * ONE_M, 0, 1'b0));
    send_pose(pose_of(0, 0, -262144, 3 * ONE_M, 0, 1'b0));
    // straight ahead: clamped, unclamped, around the distance tolerance
    send_pose(pose_of(ONE_M, ONE_M, 0, 11 * ONE_M, ONE_M, 1'b0));
    send_pose(pose_of(0, 0, 0, 4000, 0, 1'b0));
    send_pose(pose_of(0, 0, 0, 3276, 0, 1'b0));
    send_pose(pose_of(0, 0, 0, 3277, 0, 1'b0));
    send_pose(pose_of(0, 0, 0, 3278, 0, 1'b0));
    send_pose(pose_of(0, 0, 0, 2000, 0, 1'b0));
    // turn in place both ways
    send_pose(pose_of(0, 0, 0, 0, 3 * ONE_M, 1'b0));
    send_pose(pose_of(0, 0, 0, 0, -3 * ONE_M, 1'b0));
    send_pose(pose_of(-ONE_M, 0, 0, 0, 5243, 1'b0));
    drain_pipe();
  endtask

  task automatic run_batch(input int count);
    repeat (count) send_pose(random_pose());
    drain_pipe();
  endtask

  task automatic test_register_sweep();
    apply_settings(0, 0, 0, 0, 0, 0);
    run_batch(28);
    apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h3FFFF, 32'h3FFFF);
    run_batch(28);
    // upper bits beyond each register width are dropped
    apply_settings(32'hFFFF_0800, 32'h8001_2000, 32'h0F0F_0100, 32'hFFFF_FFFF,
                   32'hFFFC_0400, 32'h7FFF_0000);
    run_batch(28);
    apply_settings(1000, 500, 32'hFFFF, 32'hFFFF, 1, 1);
    run_batch(28);
    apply_settings(20000, 30000, 1, 1, 32'h3FFFF, 32'h3FFFF);
    run_batch(28);
    apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_batch(28);
    // a write past the last register must leave everything alone
    write_register(SPARE_REG, '1);
    verify_registers();
    run_batch(10);
  endtask

  task automatic test_random_traffic();
    apply_settings(gtp_pkg::RST_DIST_TOL, gtp_pkg::RST_HEAD_TOL, gtp_pkg::RST_TURN_GAIN,
                   gtp_pkg::RST_DRIVE_GAIN, gtp_pkg::RST_TURN_LIM, gtp_pkg::RST_DRIVE_LIM);
    gap_pct = 25; stall_pct = 25;
    run_batch(70);
    gap_pct = 0;  stall_pct = 0;
    run_batch(70);
    gap_pct = 50; stall_pct = 10;
    run_batch(70);
    gap_pct = 10; stall_pct = 50;
    run_batch(70);
  endtask

  task automatic test_full_rate();
    gap_pct = 0;
    stall_pct = 0;
    run_batch(80);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    settings.dist_tol   = gtp_pkg::RST_DIST_TOL;
    settings.head_tol   = gtp_pkg::RST_HEAD_TOL;
    settings.turn_gain  = gtp_pkg::RST_TURN_GAIN;
    settings.drive_gain = gtp_pkg::RST_DRIVE_GAIN;
    settings.turn_lim   = gtp_pkg::RST_TURN_LIM;
    settings.drive_lim  = gtp_pkg::RST_DRIVE_LIM;
    gap_pct   = 20;
    stall_pct = 20;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_poses();
    test_register_sweep();
    test_random_traffic();
    test_full_rate();

    $display("checked %0d commands for %0d poses under %0d register settings",
             commands_out, poses_in, settings_used);
    $display("outcomes seen: %0d turn, %0d drive, %0d reached, %0d cancel, %0d mismatches",
             mode_seen[gtp_pkg::MODE_TURN], mode_seen[gtp_pkg::MODE_DRIVE],
             mode_seen[gtp_pkg::MODE_REACHED], mode_seen[gtp_pkg::MODE_CANCEL], errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
